### src/assert_macros.svh
// Assertion macros used by the height-map interpolator core.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(label, prop, msg)
`define ASSERT_CLK(label, prop, msg)
`endif
`endif

### src/htri_pkg.sv
// Package for the height-map triangle interpolator: widths, codes, latencies
// and the structs passed between the core and its axis mapping units.
package htri_pkg;

    localparam int MAX_LEN   = 64;
    localparam int MAX_COL   = 64;
    localparam int FRAC_BITS = 16;

    localparam int PTS_W   = 7;
    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;
    localparam int SPAN_W  = HALF_W + 1;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int MAX_PTS = (MAX_LEN > MAX_COL) ? MAX_LEN : MAX_COL;
    localparam int SEG_W   = $clog2(MAX_PTS);
    localparam int CELL_W  = SEG_W;
    localparam int FRAC_W  = FRAC_BITS + 1;
    localparam int QUO_W   = SEG_W + FRAC_BITS;
    localparam int PROD_W  = SPAN_W + SEG_W;
    localparam int AXIS_LAT = QUO_W + 4;

    localparam int TRI_W     = FRAC_W + SEG_W + 1;
    localparam int ADDR_W    = 12;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int IDX_MUL_W = CELL_W + PTS_W;

    localparam int HT_W     = 32;
    localparam int HDIFF_W  = HT_W + 1;
    localparam int WPROD_W  = FRAC_W + 1 + HDIFF_W;
    localparam int ACC_W    = WPROD_W;
    localparam int RES_Q_W  = ACC_W - FRAC_BITS;

    localparam int RESULT_LAT = AXIS_LAT + 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_LEN  = 3'd0;
    localparam t_cfg_idx CFG_GRID_COL  = 3'd1;
    localparam t_cfg_idx CFG_ORIGIN_X  = 3'd2;
    localparam t_cfg_idx CFG_ORIGIN_Z  = 3'd3;
    localparam t_cfg_idx CFG_HALF_SPAN = 3'd4;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [COORD_W-1:0] origin;
        logic [HALF_W-1:0]  half;
        logic [SEG_W-1:0]   segs;
    } t_axis_cfg;

    typedef struct packed {
        logic [CELL_W-1:0] seg;
        logic [FRAC_W-1:0] frac;
        logic              clamped;
    } t_axis_res;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] index;
        logic [HT_W-1:0]   height;
    } t_item;

endpackage

### src/heightmap_triangle_interpolator_core.sv
// Height-map triangle interpolator: a query's result is on o_valid for one cycle
// and is registered through the axis units and the select, read and arithmetic
// stages; one transaction is taken every cycle while busy is low. Each axis unit
// holds a 22-stage restoring divider. Synchronous reset clears the valid bits,
// sets busy and loads the default configuration; the height store is not cleared.
// busy is high in reset and for the first cycle after it; results cannot be stalled.
`include "assert_macros.svh"
module heightmap_triangle_interpolator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_kind,
    input  logic [11:0]                        i_entry_index,
    input  logic signed [31:0]                 i_entry_height,
    input  logic signed [31:0]                 i_query_x,
    input  logic signed [31:0]                 i_query_z,
    input  logic                               i_cfg_we,
    input  logic [htri_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [htri_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output logic signed [31:0]                 o_height_out,
    output logic                               o_out_of_range
);

    localparam int AL = htri_pkg::AXIS_LAT;
    localparam int PT = htri_pkg::PTS_W;
    localparam int GW = htri_pkg::SEG_W;
    localparam int CW = htri_pkg::CELL_W;
    localparam int FW = htri_pkg::FRAC_W;
    localparam int TW = htri_pkg::TRI_W;
    localparam int AW = htri_pkg::ADDR_W;
    localparam int HW = htri_pkg::HT_W;
    localparam int DW = htri_pkg::HDIFF_W;
    localparam int PW = htri_pkg::WPROD_W;
    localparam int XW = htri_pkg::ACC_W;
    localparam int QW = htri_pkg::RES_Q_W;
    localparam int FB = htri_pkg::FRAC_BITS;

    localparam logic signed [QW-1:0] RES_MAX = {{(QW-HW+1){1'b0}}, {(HW-1){1'b1}}};
    localparam logic signed [QW-1:0] RES_MIN = {{(QW-HW+1){1'b1}}, {(HW-1){1'b0}}};

    // configuration
    logic [PT-1:0]                 r_grid_len;
    logic [PT-1:0]                 r_grid_col;
    logic [31:0]                   r_origin_x;
    logic [31:0]                   r_origin_z;
    logic [htri_pkg::HALF_W-1:0]   r_half_span;
    logic                          r_busy;

    logic [PT-1:0]                 w_len_c;
    logic [PT-1:0]                 w_col_c;
    logic [GW-1:0]                 w_lsegs;
    logic [GW-1:0]                 w_csegs;
    logic [htri_pkg::HALF_W-1:0]   w_half;
    htri_pkg::t_axis_cfg           w_cfg_x;
    htri_pkg::t_axis_cfg           w_cfg_z;
    htri_pkg::t_axis_res           w_ax;
    htri_pkg::t_axis_res           w_az;
    logic                          w_accept;

    // transaction delay line alongside the axis units
    logic [AL-1:0]                 r_pre_vld;
    htri_pkg::t_item               r_pre_dat [AL];

    // triangle select stages
    logic                          r_t1_vld;
    htri_pkg::t_item               r_t1_item;
    htri_pkg::t_axis_res           r_t1_x;
    htri_pkg::t_axis_res           r_t1_z;
    logic [TW-1:0]                 r_t1_px;
    logic [TW-1:0]                 r_t1_pz;

    logic                          r_t2_vld;
    htri_pkg::t_item               r_t2_item;
    logic [CW-1:0]                 r_t2_row [3];
    logic [CW-1:0]                 r_t2_col [3];
    logic [FW-1:0]                 r_t2_w2;
    logic [FW-1:0]                 r_t2_w3;
    logic                          r_t2_flag;
    logic [CW-1:0]                 n_row [3];
    logic [CW-1:0]                 n_col [3];
    logic [FW-1:0]                 n_w2;
    logic [FW-1:0]                 n_w3;
    logic                          w_upper;

    logic                          r_t3_vld;
    htri_pkg::t_item               r_t3_item;
    logic [AW-1:0]                 r_t3_addr [3];
    logic [FW-1:0]                 r_t3_w2;
    logic [FW-1:0]                 r_t3_w3;
    logic                          r_t3_flag;

    // height store, two copies for three reads a cycle
    logic [HW-1:0]                 r_mem_a [htri_pkg::MEM_DEPTH];
    logic [HW-1:0]                 r_mem_b [htri_pkg::MEM_DEPTH];
    logic [HW-1:0]                 r_rd1;
    logic [HW-1:0]                 r_rd2;
    logic [HW-1:0]                 r_rd3;
    logic                          r_m_vld;
    logic [FW-1:0]                 r_m_w2;
    logic [FW-1:0]                 r_m_w3;
    logic                          r_m_flag;

    // arithmetic stages
    logic                          r_d_vld;
    logic signed [HW-1:0]          r_d_y1;
    logic signed [DW-1:0]          r_d_d2;
    logic signed [DW-1:0]          r_d_d3;
    logic signed [FW:0]            r_d_w2;
    logic signed [FW:0]            r_d_w3;
    logic                          r_d_flag;

    logic                          r_p_vld;
    logic signed [HW-1:0]          r_p_y1;
    logic signed [PW-1:0]          r_p_p2;
    logic signed [PW-1:0]          r_p_p3;
    logic                          r_p_flag;

    logic                          r_a_vld;
    logic signed [XW-1:0]          r_acc;
    logic                          r_a_flag;

    logic signed [QW-1:0]          w_qfl;
    logic signed [QW-1:0]          w_qt;
    logic signed [HW-1:0]          n_height;

    logic                          r_o_vld;
    logic signed [HW-1:0]          r_o_height;
    logic                          r_o_flag;

    always_comb begin
        if (r_grid_len < PT'(2)) begin
            w_len_c = PT'(2);
        end else if (r_grid_len > PT'(htri_pkg::MAX_LEN)) begin
            w_len_c = PT'(htri_pkg::MAX_LEN);
        end else begin
            w_len_c = r_grid_len;
        end
        if (r_grid_col < PT'(2)) begin
            w_col_c = PT'(2);
        end else if (r_grid_col > PT'(htri_pkg::MAX_COL)) begin
            w_col_c = PT'(htri_pkg::MAX_COL);
        end else begin
            w_col_c = r_grid_col;
        end
    end

    assign w_lsegs  = GW'(w_len_c - PT'(1));
    assign w_csegs  = GW'(w_col_c - PT'(1));
    assign w_half   = (r_half_span == '0) ? htri_pkg::HALF_W'(1) : r_half_span;
    assign w_cfg_x  = '{origin: r_origin_x, half: w_half, segs: w_lsegs};
    assign w_cfg_z  = '{origin: r_origin_z, half: w_half, segs: w_csegs};
    assign w_accept = start & ~r_busy;
    assign busy     = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_grid_len  <= PT'(htri_pkg::MAX_LEN);
            r_grid_col  <= PT'(htri_pkg::MAX_COL);
            r_origin_x  <= '0;
            r_origin_z  <= '0;
            r_half_span <= htri_pkg::HALF_W'(32'h0001_0000);
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    htri_pkg::CFG_GRID_LEN:  r_grid_len  <= i_cfg_data[PT-1:0];
                    htri_pkg::CFG_GRID_COL:  r_grid_col  <= i_cfg_data[PT-1:0];
                    htri_pkg::CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                    htri_pkg::CFG_ORIGIN_Z:  r_origin_z  <= i_cfg_data;
                    htri_pkg::CFG_HALF_SPAN: r_half_span <= i_cfg_data[htri_pkg::HALF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    htri_axis u_axis_x (
        .i_clk   (i_clk),
        .i_coord (i_query_x),
        .i_cfg   (w_cfg_x),
        .o_res   (w_ax)
    );

    htri_axis u_axis_z (
        .i_clk   (i_clk),
        .i_coord (i_query_z),
        .i_cfg   (w_cfg_z),
        .o_res   (w_az)
    );

    // triangle test and corner choice
    assign w_upper = ({r_t1_px + r_t1_pz, 1'b0}
                   < (TW+1)'({GW'(0), 1'b0} + {({1'b0, w_lsegs} + {1'b0, w_csegs}),
                                             {FB{1'b0}}}));

    always_comb begin
        if (w_upper) begin
            n_row[0] = r_t1_z.seg;          n_col[0] = r_t1_x.seg;
            n_row[1] = r_t1_z.seg;          n_col[1] = r_t1_x.seg + CW'(1);
            n_row[2] = r_t1_z.seg + CW'(1); n_col[2] = r_t1_x.seg;
            n_w2     = r_t1_x.frac;
            n_w3     = r_t1_z.frac;
        end else begin
            n_row[0] = r_t1_z.seg + CW'(1); n_col[0] = r_t1_x.seg + CW'(1);
            n_row[1] = r_t1_z.seg + CW'(1); n_col[1] = r_t1_x.seg;
            n_row[2] = r_t1_z.seg;          n_col[2] = r_t1_x.seg + CW'(1);
            n_w2     = htri_pkg::FRAC_ONE - r_t1_x.frac;
            n_w3     = htri_pkg::FRAC_ONE - r_t1_z.frac;
        end
    end

    // scale down by 2^FRAC_BITS, rounding toward zero, then saturate
    always_comb begin
        w_qfl = $signed(r_acc[XW-1:FB]);
        w_qt  = w_qfl + QW'(r_acc[XW-1] && (r_acc[FB-1:0] != '0));
        if (w_qt > RES_MAX) begin
            n_height = RES_MAX[HW-1:0];
        end else if (w_qt < RES_MIN) begin
            n_height = RES_MIN[HW-1:0];
        end else begin
            n_height = w_qt[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= '0;
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_t3_vld  <= 1'b0;
            r_m_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_a_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_pre_vld <= {r_pre_vld[AL-2:0], w_accept};
            r_t1_vld  <= r_pre_vld[AL-1];
            r_t2_vld  <= r_t1_vld;
            r_t3_vld  <= r_t2_vld;
            r_m_vld   <= r_t3_vld && (r_t3_item.kind == htri_pkg::KIND_QUERY);
            r_d_vld   <= r_m_vld;
            r_p_vld   <= r_d_vld;
            r_a_vld   <= r_p_vld;
            r_o_vld   <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre_dat[0] <= '{kind: htri_pkg::t_kind'(i_kind), index: i_entry_index,
                          height: i_entry_height};
        for (int i = 1; i < AL; i++) begin
            r_pre_dat[i] <= r_pre_dat[i-1];
        end

        r_t1_item <= r_pre_dat[AL-1];
        r_t1_x    <= w_ax;
        r_t1_z    <= w_az;
        r_t1_px   <= TW'(w_ax.frac) * TW'(w_csegs);
        r_t1_pz   <= TW'(w_az.frac) * TW'(w_lsegs);

        r_t2_item <= r_t1_item;
        r_t2_row  <= n_row;
        r_t2_col  <= n_col;
        r_t2_w2   <= n_w2;
        r_t2_w3   <= n_w3;
        r_t2_flag <= r_t1_x.clamped | r_t1_z.clamped;

        r_t3_item <= r_t2_item;
        for (int k = 0; k < 3; k++) begin
            r_t3_addr[k] <= AW'(htri_pkg::IDX_MUL_W'(r_t2_row[k])
                              * htri_pkg::IDX_MUL_W'(w_len_c)
                              + htri_pkg::IDX_MUL_W'(r_t2_col[k]));
        end
        r_t3_w2   <= r_t2_w2;
        r_t3_w3   <= r_t2_w3;
        r_t3_flag <= r_t2_flag;

        r_m_w2    <= r_t3_w2;
        r_m_w3    <= r_t3_w3;
        r_m_flag  <= r_t3_flag;

        r_d_y1    <= $signed(r_rd1);
        r_d_d2    <= {r_rd2[HW-1], r_rd2} - {r_rd1[HW-1], r_rd1};
        r_d_d3    <= {r_rd3[HW-1], r_rd3} - {r_rd1[HW-1], r_rd1};
        r_d_w2    <= {1'b0, r_m_w2};
        r_d_w3    <= {1'b0, r_m_w3};
        r_d_flag  <= r_m_flag;

        r_p_y1    <= r_d_y1;
        r_p_p2    <= PW'(r_d_w2) * PW'(r_d_d2);
        r_p_p3    <= PW'(r_d_w3) * PW'(r_d_d3);
        r_p_flag  <= r_d_flag;

        r_acc     <= (XW'(r_p_y1) <<< FB) + r_p_p2 + r_p_p3;
        r_a_flag  <= r_p_flag;

        r_o_height <= n_height;
        r_o_flag   <= r_a_flag;
    end

    // writes reach the store in the same stage as query reads, so order holds
    always_ff @(posedge i_clk) begin
        if (r_t3_vld && (r_t3_item.kind == htri_pkg::KIND_WRITE)) begin
            r_mem_a[r_t3_item.index] <= r_t3_item.height;
            r_mem_b[r_t3_item.index] <= r_t3_item.height;
        end
        r_rd1 <= r_mem_a[r_t3_addr[0]];
        r_rd2 <= r_mem_a[r_t3_addr[1]];
        r_rd3 <= r_mem_b[r_t3_addr[2]];
    end

    assign o_valid        = r_o_vld;
    assign o_height_out   = r_o_height;
    assign o_out_of_range = r_o_flag;

    `ASSERT_CLKD(a_query_result,
        (start && !busy && i_kind == htri_pkg::KIND_QUERY) |-> ##(htri_pkg::RESULT_LAT) o_valid,
        "query transaction did not produce a result on time")
    `ASSERT_CLKD(a_write_silent,
        (start && !busy && i_kind == htri_pkg::KIND_WRITE) |-> ##(htri_pkg::RESULT_LAT) !o_valid,
        "write transaction produced a result")
    `ASSERT_CLK(a_reset_quiet,
        $rose(i_rst_n) |-> (!o_valid && busy),
        "result strobe or ready seen straight out of reset")

endmodule

### src/htri_axis.sv
// One axis of the world-to-grid mapping: offset, clamp, scale and a
// pipelined restoring divider giving cell and fraction. Uses htri_pkg.
module htri_axis (
    input  logic                          i_clk,
    input  logic [htri_pkg::COORD_W-1:0]  i_coord,
    input  htri_pkg::t_axis_cfg           i_cfg,
    output htri_pkg::t_axis_res           o_res
);

    localparam int QW = htri_pkg::QUO_W;
    localparam int SW = htri_pkg::SPAN_W;
    localparam int DW = htri_pkg::DIFF_W;
    localparam int CW = htri_pkg::COORD_W;
    localparam int PW = htri_pkg::PROD_W;
    localparam int GW = htri_pkg::SEG_W;
    localparam int FB = htri_pkg::FRAC_BITS;

    logic [SW-1:0]        w_span;
    logic signed [DW-1:0] r_diff;
    logic [SW-1:0]        n_n;
    logic                 n_flag;
    logic [SW-1:0]        r_n;
    logic                 r_flag2;
    logic [PW-1:0]        r_prod;
    logic                 r_flag3;
    logic [SW-1:0]        r_rem [QW];
    logic [QW-1:0]        r_low [QW];
    logic [QW-1:0]        r_q   [QW];
    logic                 r_flg [QW];
    logic [GW-1:0]        w_qi;
    htri_pkg::t_axis_res  n_res;
    htri_pkg::t_axis_res  r_res;

    assign w_span = {i_cfg.half, 1'b0};

    always_comb begin
        n_n    = r_diff[SW-1:0];
        n_flag = 1'b0;
        if (r_diff[DW-1]) begin
            n_n    = '0;
            n_flag = 1'b1;
        end else if (r_diff[DW-2:0] > {1'b0, w_span}) begin
            n_n    = w_span;
            n_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff  <= {{(DW-CW){i_coord[CW-1]}}, i_coord}
                 - {{(DW-CW){i_cfg.origin[CW-1]}}, i_cfg.origin}
                 + {{(DW-htri_pkg::HALF_W){1'b0}}, i_cfg.half};
        r_n     <= n_n;
        r_flag2 <= n_flag;
        r_prod  <= PW'(r_n) * PW'(i_cfg.segs);
        r_flag3 <= r_flag2;
    end

    // one quotient bit per stage; dividend is r_prod shifted up by FRAC_BITS
    for (genvar i = 0; i < QW; i++) begin : g_div
        logic [SW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic          flg_in;
        logic [SW:0]   trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = r_prod[PW-1:GW];
            assign low_in = {r_prod[GW-1:0], {FB{1'b0}}};
            assign q_in   = '0;
            assign flg_in = r_flag3;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign low_in = r_low[i-1];
            assign q_in   = r_q[i-1];
            assign flg_in = r_flg[i-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = (trial >= {1'b0, w_span});

        always_ff @(posedge i_clk) begin
            r_rem[i] <= ge ? SW'(trial - {1'b0, w_span}) : trial[SW-1:0];
            r_low[i] <= low_in << 1;
            r_q[i]   <= {q_in[QW-2:0], ge};
            r_flg[i] <= flg_in;
        end
    end

    assign w_qi = r_q[QW-1][QW-1:FB];

    // far edge: previous cell with a full fraction
    always_comb begin
        n_res.clamped = r_flg[QW-1];
        if (w_qi >= i_cfg.segs) begin
            n_res.seg  = i_cfg.segs - GW'(1);
            n_res.frac = htri_pkg::FRAC_ONE;
        end else begin
            n_res.seg  = w_qi;
            n_res.frac = {1'b0, r_q[QW-1][FB-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
